### rtl/core/lik_pkg.sv
// ----------------------------------------------------------------------------
// lik_pkg: shared types and constants for the leg inverse kinematics core
// Operand widths, CORDIC arc table, normalizer schedule, register indexes.
// ----------------------------------------------------------------------------
package lik_pkg;

  localparam int SQRT_STAGES  = 32;
  localparam int CORDIC_STEPS = 23;
  localparam int NORM_STAGES  = 8;
  localparam int NORM_RIGHT   = 3;
  // head + normalizer + rotations + quadrant fixup
  localparam int ATAN_STAGES  = 1 + NORM_STAGES + CORDIC_STEPS + 1;

  localparam int ARG_W  = 34;  // signed atan2 operand
  localparam int ANG_W  = 25;  // signed Q.16 degrees, +/-180
  localparam int DIFF_W = 26;  // difference of two angles

  typedef logic signed [ARG_W-1:0]  arg_t;
  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  // atan(2^-i) in Q.16 degrees
  localparam logic [21:0] ARC_TABLE [CORDIC_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
    22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2,
    22'd1
  };

  // Normalizer: three right steps bring the larger magnitude below 2^29,
  // then left steps bring it to 2^28 or above.
  localparam int NORM_SHIFT [NORM_STAGES] = '{2, 1, 1, 16, 8, 4, 2, 1};
  localparam logic [32:0] NORM_LIMIT [NORM_STAGES] = '{
    33'h0_8000_0000, 33'h0_4000_0000, 33'h0_2000_0000, 33'h0_0000_2000,
    33'h0_0020_0000, 33'h0_0200_0000, 33'h0_0800_0000, 33'h0_1000_0000
  };

  localparam ang_t  DEG90_Q16     = 25'sd5898240;
  localparam ang_t  DEG180_Q16    = 25'sd11796480;
  localparam diff_t HALF_TURN_Q7  = 26'sd23040;
  localparam diff_t FULL_TURN_Q7  = 26'sd46080;

  localparam logic [13:0] UPPER_RESET = 14'd800;
  localparam logic [13:0] LOWER_RESET = 14'd1200;

  typedef enum logic [1:0] {
    REG_UPPER_LENGTH = 2'd0,
    REG_LOWER_LENGTH = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [32:0] ax;
    logic [32:0] ay;
    logic        xneg;
    logic        yneg;
    logic        zero;
  } norm_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    ang_t               z;
    logic               xneg;
    logic               yneg;
    logic               zero;
  } cordic_t;

endpackage

### rtl/core/lik_delay.sv
// ----------------------------------------------------------------------------
// lik_delay: register line
// Carries side data alongside the arithmetic chains, one cell per clock while ce is high.
// ----------------------------------------------------------------------------
module lik_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] src;
    if (i == 0) begin : g_head
      assign src = d;
    end else begin : g_link
      assign src = line[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        line[i] <= '0;
      end else if (ce) begin
        line[i] <= src;
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

### rtl/core/lik_sqrt.sv
// ----------------------------------------------------------------------------
// lik_sqrt: pipelined integer square root
// One result bit per cell, floor of the root of a 64-bit argument.
// ----------------------------------------------------------------------------
module lik_sqrt import lik_pkg::*; (
  input  logic        clk,
  input  logic        ce,
  input  logic [63:0] arg,
  output logic [31:0] root
);

  logic [63:0] v_q [SQRT_STAGES];
  logic [63:0] r_q [SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_cell
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] v_in, r_in, trial;
    if (i == 0) begin : g_head
      assign v_in = arg;
      assign r_in = '0;
    end else begin : g_link
      assign v_in = v_q[i-1];
      assign r_in = r_q[i-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk) begin
      if (ce) begin
        if (v_in >= trial) begin
          v_q[i] <= v_in - trial;
          r_q[i] <= (r_in >> 1) + BIT;
        end else begin
          v_q[i] <= v_in;
          r_q[i] <= r_in >> 1;
        end
      end
    end
  end

  assign root = r_q[SQRT_STAGES-1][31:0];

endmodule

### rtl/core/lik_atan2.sv
// ----------------------------------------------------------------------------
// lik_atan2: pipelined four-quadrant arctangent
// Magnitudes, normalize, 23 CORDIC vectoring cells, quadrant fixup.
// ----------------------------------------------------------------------------
module lik_atan2 import lik_pkg::*; (
  input  logic clk,
  input  logic ce,
  input  arg_t y_in,
  input  arg_t x_in,
  output ang_t angle
);

  norm_t   norm_q   [NORM_STAGES+1];
  cordic_t cordic_q [CORDIC_STEPS];
  cordic_t tail;
  ang_t    zc, a;

  // head: magnitudes and signs
  always_ff @(posedge clk) begin
    if (ce) begin
      norm_q[0].ax   <= 33'(x_in[ARG_W-1] ? -x_in : x_in);
      norm_q[0].ay   <= 33'(y_in[ARG_W-1] ? -y_in : y_in);
      norm_q[0].xneg <= x_in[ARG_W-1];
      norm_q[0].yneg <= y_in[ARG_W-1];
      norm_q[0].zero <= (x_in == '0) && (y_in == '0);
    end
  end

  for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
    localparam int          SH  = NORM_SHIFT[j];
    localparam logic [32:0] LIM = NORM_LIMIT[j];
    logic [32:0] m;
    norm_t       nxt;
    assign m = (norm_q[j].ax > norm_q[j].ay) ? norm_q[j].ax : norm_q[j].ay;
    always_comb begin
      nxt = norm_q[j];
      if (j < NORM_RIGHT) begin
        if (m >= LIM) begin
          nxt.ax = norm_q[j].ax >> SH;
          nxt.ay = norm_q[j].ay >> SH;
        end
      end else if (m < LIM) begin
        nxt.ax = norm_q[j].ax << SH;
        nxt.ay = norm_q[j].ay << SH;
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        norm_q[j+1] <= nxt;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam ang_t STEP_ARC = ang_t'({3'b000, ARC_TABLE[i]});
    cordic_t cur, nxt;
    logic signed [31:0] xm, ym, xs, ys;
    if (i == 0) begin : g_head
      always_comb begin
        cur.x    = signed'(32'(norm_q[NORM_STAGES].ax));
        cur.y    = signed'(32'(norm_q[NORM_STAGES].ay));
        cur.z    = '0;
        cur.xneg = norm_q[NORM_STAGES].xneg;
        cur.yneg = norm_q[NORM_STAGES].yneg;
        cur.zero = norm_q[NORM_STAGES].zero;
      end
    end else begin : g_link
      assign cur = cordic_q[i-1];
    end
    // shifts truncate toward zero
    always_comb begin
      xm  = cur.x[31] ? -cur.x : cur.x;
      ym  = cur.y[31] ? -cur.y : cur.y;
      xs  = cur.x[31] ? -(xm >>> i) : (xm >>> i);
      ys  = cur.y[31] ? -(ym >>> i) : (ym >>> i);
      nxt = cur;
      if (!cur.y[31]) begin
        nxt.x = cur.x + ys;
        nxt.y = cur.y - xs;
        nxt.z = cur.z + STEP_ARC;
      end else begin
        nxt.x = cur.x - ys;
        nxt.y = cur.y + xs;
        nxt.z = cur.z - STEP_ARC;
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        cordic_q[i] <= nxt;
      end
    end
  end

  // clamp to [0, 90], then mirror into the quadrant
  always_comb begin
    tail = cordic_q[CORDIC_STEPS-1];
    if (tail.z < 0) begin
      zc = '0;
    end else if (tail.z > DEG90_Q16) begin
      zc = DEG90_Q16;
    end else begin
      zc = tail.z;
    end
    a = tail.zero ? '0 : zc;
    if (tail.xneg) begin
      a = DEG180_Q16 - a;
    end
    if (tail.yneg) begin
      a = -a;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      angle <= a;
    end
  end

endmodule

### rtl/core/leg_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// leg_inverse_kinematics: three-joint leg inverse kinematics pipeline
// Foot target (x, y, z) in, hip/upper/lower joint angles and reach flag out.
// ----------------------------------------------------------------------------
// Takes one foot target word per clock and returns one angle word per target,
// in order, through the capture stage, stages A to E, the 32-cell square-root
// chain, the 33-cell arctangent chain, stage F and the output register; every
// cell is a plain register stage, so a new target can enter every cycle and
// throughput is one word per clock as long as the sink keeps m_tready high.
// The whole pipeline holds while a finished word waits in the output register.
// Coordinates are signed Q.4 mm, segment lengths unsigned Q10.4 mm, angles
// signed Q9.7 degrees wrapped to +/-180. A target that is out of reach, at the
// origin, or used with a zero segment length yields zero angles and a cleared
// reach flag. Segment lengths are written through the cfg port (index 0 upper,
// 1 lower, other indexes ignored) and must only change while no target is in
// flight.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics import lik_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // target: x [W-1:0], y [2W-1:W], z [3W-1:2W], zero pad to bytes
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
  // angles: hip [15:0], upper [31:16], lower [47:32]
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [47:0]                           m_tdata,
  // reachable [0]
  output logic                                  m_tuser,
  // segment length writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [13:0]                           cfg_data
);

  localparam int W     = COORD_WIDTH;
  localparam int SQ_W  = 2 * W;
  localparam int XY_W  = SQ_W + 1;
  localparam int D2_W  = SQ_W + 2;
  localparam int CMP_W = (D2_W > 30) ? D2_W : 30;

  typedef struct packed {
    logic valid;
    logic reach;
    arg_t x;
    arg_t y;
    arg_t z16;
    arg_t n;
    arg_t mm;
  } side_t;

  typedef struct packed {
    logic valid;
    logic reach;
  } flag_t;

  // round Q.16 to Q9.7 half away from zero, wrap once into +/-180
  function automatic logic signed [15:0] to_q7(input diff_t a);
    logic [DIFF_W-1:0] mag;
    logic [DIFF_W-1:0] qm;
    diff_t             q;
    mag = a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
    qm  = (mag + DIFF_W'(256)) >> 9;
    q   = a[DIFF_W-1] ? -signed'(qm) : signed'(qm);
    if (q > HALF_TURN_Q7) begin
      q = q - FULL_TURN_Q7;
    end
    if (q < -HALF_TURN_Q7) begin
      q = q + FULL_TURN_Q7;
    end
    return 16'(q);
  endfunction

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [13:0] upper_len, lower_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= UPPER_RESET;
      lower_len <= LOWER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UPPER_LENGTH: upper_len <= cfg_data;
        REG_LOWER_LENGTH: lower_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // flow control: whole pipe advances unless the output word is stuck
  // --------------------------------------------------------------------------
  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // stage 0: capture target
  logic                v0;
  logic signed [W-1:0] x0, y0, z0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ce) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x0 <= s_tdata[W-1:0];
      y0 <= s_tdata[2*W-1:W];
      z0 <= s_tdata[3*W-1:2*W];
    end
  end

  // stage A: squares of the coordinates and of the segment terms
  logic [W-1:0]  ux, uy, uz;
  logic [14:0]   len_sum;
  logic [13:0]   len_dif;
  logic          v_a, unz_a, lnz_a;
  logic [SQ_W-1:0] ux2_a, uy2_a, uz2_a;
  logic [27:0]   uu_a, ll_a, ul_a, dif2_a;
  logic [29:0]   sum2_a;
  arg_t          x_a, y_a, z_a;

  assign ux      = W'(x0[W-1] ? -x0 : x0);
  assign uy      = W'(y0[W-1] ? -y0 : y0);
  assign uz      = W'(z0[W-1] ? -z0 : z0);
  assign len_sum = 15'(upper_len) + 15'(lower_len);
  assign len_dif = (upper_len > lower_len) ? upper_len - lower_len
                                           : lower_len - upper_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (ce) begin
      v_a <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ux2_a  <= SQ_W'(ux) * SQ_W'(ux);
      uy2_a  <= SQ_W'(uy) * SQ_W'(uy);
      uz2_a  <= SQ_W'(uz) * SQ_W'(uz);
      uu_a   <= 28'(upper_len) * 28'(upper_len);
      ll_a   <= 28'(lower_len) * 28'(lower_len);
      ul_a   <= 28'(upper_len) * 28'(lower_len);
      sum2_a <= 30'(len_sum) * 30'(len_sum);
      dif2_a <= 28'(len_dif) * 28'(len_dif);
      unz_a  <= upper_len != '0;
      lnz_a  <= lower_len != '0;
      x_a    <= ARG_W'(x0);
      y_a    <= ARG_W'(y0);
      z_a    <= ARG_W'(z0);
    end
  end

  // stage B: squared distances
  logic            v_b, unz_b, lnz_b;
  logic [D2_W-1:0] d2_b;
  logic [XY_W-1:0] xy2_b;
  logic [27:0]     uu_b, ll_b, ul_b, dif2_b;
  logic [29:0]     sum2_b;
  arg_t            x_b, y_b, z_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (ce) begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d2_b   <= D2_W'(ux2_a) + D2_W'(uy2_a) + D2_W'(uz2_a);
      xy2_b  <= XY_W'(ux2_a) + XY_W'(uy2_a);
      uu_b   <= uu_a;
      ll_b   <= ll_a;
      ul_b   <= ul_a;
      sum2_b <= sum2_a;
      dif2_b <= dif2_a;
      unz_b  <= unz_a;
      lnz_b  <= lnz_a;
      x_b    <= x_a;
      y_b    <= y_a;
      z_b    <= z_a;
    end
  end

  // stage C: reach test, cosine-law numerators
  // once reachable d^2 < 2^30, so the arithmetic below runs on narrow values
  logic [29:0] d2n;
  logic        v_c, reach_c;
  arg_t        n_c, mm_c, x_c, y_c, z_c;
  logic [28:0] dd_c;
  logic [29:0] d2_c, xy2_c;
  logic [27:0] uu_c;

  assign d2n = 30'(d2_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else if (ce) begin
      v_c <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      reach_c <= unz_b && lnz_b && (d2_b != '0) &&
                 (CMP_W'(d2_b) >= CMP_W'(dif2_b)) &&
                 (CMP_W'(d2_b) <= CMP_W'(sum2_b));
      n_c     <= signed'(ARG_W'(uu_b) + ARG_W'(ll_b) - ARG_W'(d2n));
      mm_c    <= signed'(ARG_W'(uu_b) + ARG_W'(d2n) - ARG_W'(ll_b));
      dd_c    <= 29'({ul_b, 1'b0});
      d2_c    <= d2n;
      xy2_c   <= 30'(xy2_b);
      uu_c    <= uu_b;
      x_c     <= x_b;
      y_c     <= y_b;
      z_c     <= z_b;
    end
  end

  // stage D: squares for the square-root arguments
  logic [28:0] nmag;
  logic [29:0] mmag;
  logic        v_d, reach_d;
  logic [57:0] nn_d, dd2_d;
  logic [59:0] m2_d, e4_d;
  logic [29:0] xy2_d;
  arg_t        n_d, mm_d, x_d, y_d, z_d;

  assign nmag = 29'(n_c[ARG_W-1] ? -n_c : n_c);
  assign mmag = 30'(mm_c[ARG_W-1] ? -mm_c : mm_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= 1'b0;
    end else if (ce) begin
      v_d <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      nn_d    <= 58'(nmag) * 58'(nmag);
      dd2_d   <= 58'(dd_c) * 58'(dd_c);
      m2_d    <= 60'(mmag) * 60'(mmag);
      e4_d    <= (60'(uu_c) * 60'(d2_c)) << 2;
      xy2_d   <= xy2_c;
      reach_d <= reach_c;
      n_d     <= n_c;
      mm_d    <= mm_c;
      x_d     <= x_c;
      y_d     <= y_c;
      z_d     <= z_c;
    end
  end

  // stage E: square-root arguments, floored at zero
  logic [63:0] s_arg, e_arg, r_arg;
  side_t       side_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_e.valid <= 1'b0;
    end else if (ce) begin
      side_e.valid <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s_arg        <= (dd2_d > nn_d) ? 64'(dd2_d - nn_d) : '0;
      e_arg        <= (e4_d > m2_d) ? 64'(e4_d - m2_d) : '0;
      r_arg        <= {2'b00, xy2_d, 32'h0000_0000};
      side_e.reach <= reach_d;
      side_e.x     <= x_d;
      side_e.y     <= y_d;
      side_e.z16   <= z_d <<< 16;
      side_e.n     <= n_d;
      side_e.mm    <= mm_d;
    end
  end

  // --------------------------------------------------------------------------
  // square roots: knee sine term, hip-plane radius, beta sine term
  // --------------------------------------------------------------------------
  logic [31:0] s_root, r_root, e_root;
  side_t       side_s;

  lik_sqrt u_sqrt_s (.clk(clk), .ce(ce), .arg(s_arg), .root(s_root));
  lik_sqrt u_sqrt_r (.clk(clk), .ce(ce), .arg(r_arg), .root(r_root));
  lik_sqrt u_sqrt_e (.clk(clk), .ce(ce), .arg(e_arg), .root(e_root));

  lik_delay #(.WIDTH($bits(side_t)), .DEPTH(SQRT_STAGES)) u_side_dly (
    .clk(clk), .rst(rst), .ce(ce), .d(side_e), .q(side_s)
  );

  // --------------------------------------------------------------------------
  // arctangents
  // --------------------------------------------------------------------------
  ang_t  hip_a, low_a, alpha_a, beta_a;
  flag_t flag_s, flag_t_out;

  assign flag_s.valid = side_s.valid;
  assign flag_s.reach = side_s.reach;

  lik_atan2 u_atan_hip (
    .clk(clk), .ce(ce), .y_in(side_s.y), .x_in(side_s.x), .angle(hip_a)
  );
  lik_atan2 u_atan_low (
    .clk(clk), .ce(ce), .y_in(signed'(ARG_W'(s_root))), .x_in(side_s.n),
    .angle(low_a)
  );
  lik_atan2 u_atan_alpha (
    .clk(clk), .ce(ce), .y_in(side_s.z16), .x_in(signed'(ARG_W'(r_root))),
    .angle(alpha_a)
  );
  lik_atan2 u_atan_beta (
    .clk(clk), .ce(ce), .y_in(signed'(ARG_W'(e_root))), .x_in(side_s.mm),
    .angle(beta_a)
  );

  lik_delay #(.WIDTH($bits(flag_t)), .DEPTH(ATAN_STAGES)) u_flag_dly (
    .clk(clk), .rst(rst), .ce(ce), .d(flag_s), .q(flag_t_out)
  );

  // stage F: joint angle differences
  logic  v_f, reach_f;
  diff_t hip_f, low_f, up_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f <= 1'b0;
    end else if (ce) begin
      v_f <= flag_t_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      reach_f <= flag_t_out.reach;
      hip_f   <= DIFF_W'(hip_a);
      low_f   <= DIFF_W'(low_a) - DIFF_W'(DEG180_Q16);
      up_f    <= DIFF_W'(alpha_a) - DIFF_W'(beta_a);
    end
  end

  // output register: rounding, wrap, zeroing when out of reach
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= v_f;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tuser <= reach_f;
      m_tdata <= reach_f ? {to_q7(low_f), to_q7(up_f), to_q7(hip_f)} : '0;
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  logic signed [15:0] hip_out, lower_out;
  assign hip_out   = m_tdata[15:0];
  assign lower_out = m_tdata[47:32];

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("unreachable word carries nonzero angles");

  a_lower_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> lower_out <= 16'sd0 && lower_out >= -16'sd23040)
    else $error("lower angle outside [-180, 0]");

  a_hip_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> hip_out <= 16'sd23040 && hip_out >= -16'sd23040)
    else $error("hip angle outside +/-180");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output word valid right after reset");

endmodule
